// ----- hdl/dmfp_pkg.sv -----
`default_nettype none

package dmfp_pkg;

   localparam int MAX_MESSAGE_BYTES_DEF = 65535;

   typedef enum logic [4:0] {
      PH_ID        = 5'd0,
      PH_FLAGS     = 5'd1,
      PH_QDCOUNT   = 5'd2,
      PH_ANCOUNT   = 5'd3,
      PH_NSCOUNT   = 5'd4,
      PH_ARCOUNT   = 5'd5,
      PH_LABELLEN  = 5'd6,
      PH_LABELBYTE = 5'd7,
      PH_NAMEEND   = 5'd8,
      PH_QTYPE     = 5'd9,
      PH_QCLASS    = 5'd10,
      PH_ANSNAME   = 5'd11,
      PH_TYPE      = 5'd12,
      PH_CLASS     = 5'd13,
      PH_TTL       = 5'd14,
      PH_RDLENGTH  = 5'd15,
      PH_RDATA     = 5'd16,
      PH_TRAILING  = 5'd17
   } phase_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last_byte;
   } dmfp_req_type;

   typedef struct packed {
      logic [4:0]  section_tag;
      logic [31:0] field_value;
      logic        field_complete;
      logic [15:0] record_index;
      logic [7:0]  label_index;
      logic [15:0] byte_offset;
      logic        truncated;
      logic        message_end;
   } dmfp_rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  field_byte_count;
      logic [31:0] field_accumulator;
      logic [15:0] question_total;
      logic [15:0] answer_total;
      logic [15:0] record_counter;
      logic [7:0]  label_remaining;
      logic [7:0]  label_counter;
      logic [15:0] rdata_remaining;
      logic [15:0] offset_counter;
   } dmfp_state_type;

   localparam dmfp_state_type STATE_RESET = '{
      phase:             PH_ID,
      field_byte_count:  3'd0,
      field_accumulator: 32'd0,
      question_total:    16'd0,
      answer_total:      16'd0,
      record_counter:    16'd0,
      label_remaining:   8'd0,
      label_counter:     8'd0,
      rdata_remaining:   16'd0,
      offset_counter:    16'd0
   };

endpackage

`default_nettype wire

// ----- hdl/dmfp_step.sv -----
`default_nettype none

module dmfp_step
   import dmfp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
   input  wire dmfp_state_type state,
   input  wire dmfp_req_type   item,
   output dmfp_state_type state_next,
   output dmfp_rsp_type   result
);

   dmfp_state_type nx;
   phase_type      ph;
   logic [7:0]     b;
   logic [4:0]     tag;
   logic [31:0]    value;
   logic           complete;
   logic [31:0]    acc_new;
   logic [2:0]     cnt_new;
   logic [2:0]     len;
   logic [7:0]     lrem_new;
   logic [15:0]    rrem_new;
   logic [16:0]    rec_inc;
   logic           q_more;
   logic           a_more;
   phase_type      answers_entry;

   assign rec_inc       = {1'b0, state.record_counter} + 17'd1;
   assign q_more        = rec_inc < {1'b0, state.question_total};
   assign a_more        = rec_inc < {1'b0, state.answer_total};
   assign answers_entry = (state.answer_total != 16'd0) ? PH_ANSNAME : PH_TRAILING;
   assign acc_new       = (state.field_byte_count == 3'd0) ? {24'd0, item.msg_byte}
                                                           : {state.field_accumulator[23:0],
                                                              item.msg_byte};
   assign cnt_new       = state.field_byte_count + 3'd1;
   assign lrem_new      = state.label_remaining - 8'd1;
   assign rrem_new      = state.rdata_remaining - 16'd1;

   always_comb begin
      ph       = state.phase;
      b        = item.msg_byte;
      nx       = state;
      tag      = ph;
      value    = {24'd0, b};
      complete = 1'b0;
      len      = 3'd2;

      unique case (ph)
         PH_LABELLEN: begin
            complete = 1'b1;
            if (b == 8'd0) begin
               tag      = PH_NAMEEND;
               nx.phase = PH_QTYPE;
            end else begin
               nx.label_remaining = b;
               nx.phase           = PH_LABELBYTE;
            end
         end
         PH_LABELBYTE: begin
            nx.label_remaining = lrem_new;
            if (lrem_new == 8'd0) begin
               complete         = 1'b1;
               nx.label_counter = state.label_counter + 8'd1;
               nx.phase         = PH_LABELLEN;
            end
         end
         PH_RDATA: begin
            nx.rdata_remaining = rrem_new;
            if (rrem_new == 16'd0) begin
               complete = 1'b1;
               if (a_more) begin
                  nx.record_counter = rec_inc[15:0];
                  nx.phase          = PH_ANSNAME;
               end else begin
                  nx.record_counter = 16'd0;
                  nx.phase          = PH_TRAILING;
               end
            end
         end
         PH_TRAILING: begin
            complete = 1'b1;
         end
         default: begin
            if (ph == PH_TTL) begin
               len = 3'd4;
            end else if (ph == PH_NAMEEND) begin
               len = 3'd1;
            end
            nx.field_accumulator = acc_new;
            nx.field_byte_count  = cnt_new;
            value                = acc_new;
            if (cnt_new >= len) begin
               complete            = 1'b1;
               nx.field_byte_count = 3'd0;
               if (ph == PH_QDCOUNT) begin
                  nx.question_total = acc_new[15:0];
               end
               if (ph == PH_ANCOUNT) begin
                  nx.answer_total = acc_new[15:0];
               end
               priority if (ph < PH_ARCOUNT) begin
                  nx.phase = phase_type'(ph + 5'd1);
               end else if (ph == PH_ARCOUNT) begin
                  nx.record_counter = 16'd0;
                  if (state.question_total != 16'd0) begin
                     nx.phase           = PH_LABELLEN;
                     nx.label_counter   = 8'd0;
                     nx.label_remaining = 8'd0;
                  end else begin
                     nx.phase = answers_entry;
                  end
               end else if (ph == PH_QCLASS) begin
                  if (q_more) begin
                     nx.record_counter  = rec_inc[15:0];
                     nx.phase           = PH_LABELLEN;
                     nx.label_counter   = 8'd0;
                     nx.label_remaining = 8'd0;
                  end else begin
                     nx.record_counter = 16'd0;
                     nx.phase          = answers_entry;
                  end
               end else if (ph == PH_RDLENGTH) begin
                  nx.rdata_remaining = acc_new[15:0];
                  if (acc_new[15:0] != 16'd0) begin
                     nx.phase = PH_RDATA;
                  end else if (a_more) begin
                     nx.record_counter = rec_inc[15:0];
                     nx.phase          = PH_ANSNAME;
                  end else begin
                     nx.record_counter = 16'd0;
                     nx.phase          = PH_TRAILING;
                  end
               end else begin
                  nx.phase = phase_type'(ph + 5'd1);
               end
            end
         end
      endcase

      if (state.offset_counter < 16'(MAX_MESSAGE_BYTES)) begin
         nx.offset_counter = state.offset_counter + 16'd1;
      end

      result.section_tag    = tag;
      result.field_value    = value;
      result.field_complete = complete;
      result.record_index   = (ph >= PH_LABELLEN && ph <= PH_RDATA) ? state.record_counter
                                                                     : 16'd0;
      result.label_index    = (ph == PH_LABELLEN || ph == PH_LABELBYTE) ? state.label_counter
                                                                         : 8'd0;
      result.byte_offset    = state.offset_counter;
      result.truncated      = item.last_byte && (nx.phase != PH_TRAILING);
      result.message_end    = item.last_byte;

      state_next = item.last_byte ? STATE_RESET : nx;
   end

endmodule

`default_nettype wire

// ----- hdl/dns_message_field_parser_core.sv -----
// DNS message field parser: takes one message byte per transaction and returns one
// result per byte, tagging it as a header word, question label, answer record field
// or trailing byte, with multi-byte fields assembled big-endian. A byte is registered
// on entry, classified by a single parse-state update, and its result registered on
// exit; throughput is one byte per cycle while the response side is not stalled by
// rsp_ready. The final byte of a message (last_byte) returns the parser to its reset
// state, so the next byte starts a new message.
`default_nettype none

module dns_message_field_parser_core
   import dmfp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   input  wire dmfp_req_type req_data,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output dmfp_rsp_type rsp_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   dmfp_req_type   in_data_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   dmfp_rsp_type   out_data_ff;
   dmfp_state_type state_ff;
   dmfp_state_type state_in;
   dmfp_rsp_type   step_result;
   logic           advance;

   dmfp_step #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_step (
      .state     (state_ff),
      .item      (in_data_ff),
      .state_next(state_in),
      .result    (step_result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   a_held_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held input transaction lost or changed");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last_byte |=> state_ff.phase == PH_ID
         && state_ff.offset_counter == 16'd0 && state_ff.field_byte_count == 3'd0)
      else $error("parser state not cleared after message end");

   a_trunc_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.truncated |-> out_data_ff.message_end)
      else $error("truncated flagged away from message end");

   a_header_rec: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.section_tag <= PH_ARCOUNT
         |-> out_data_ff.record_index == 16'd0 && out_data_ff.label_index == 8'd0)
      else $error("header word carries a record or label index");

   a_trailing_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.section_tag == PH_TRAILING |-> out_data_ff.field_complete)
      else $error("trailing byte not marked complete");

endmodule

`default_nettype wire
